[src/tkpc_pkg.sv]
// Shared types and constants for the two-key press classifier.
// Used by every module of the block and by its checker; depends on nothing.
`default_nettype none

package tkpc_pkg;

    // Event codes for one key
    localparam logic [1:0] EV_NONE  = 2'd0;
    localparam logic [1:0] EV_SHORT = 2'd1;
    localparam logic [1:0] EV_LONG  = 2'd2;
    localparam logic [1:0] EV_HOLD  = 2'd3;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_SHORT_MIN       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_MARK       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RELEASE_TICKS   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COMBO_MARK      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_OTHER_KEY_LIMIT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SELFTEST_LIMIT  = 3'd5;

    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned QUIET_W    = 8;

    // Reset values of the configuration registers
    localparam logic [15:0]        RST_SHORT_MIN       = 16'd20;
    localparam logic [15:0]        RST_LONG_MARK       = 16'd500;
    localparam logic [QUIET_W-1:0] RST_RELEASE_TICKS   = 8'd30;
    localparam logic [15:0]        RST_COMBO_MARK      = 16'd100;
    localparam logic [15:0]        RST_OTHER_KEY_LIMIT = 16'd50;
    localparam logic [15:0]        RST_SELFTEST_LIMIT  = 16'd1000;

    typedef struct packed {
        logic [15:0]        short_min;
        logic [15:0]        long_mark;
        logic [QUIET_W-1:0] release_ticks;
        logic [15:0]        combo_mark;
        logic [15:0]        other_key_limit;
        logic [15:0]        selftest_limit;
    } cfg_t;

    typedef struct packed {
        logic [1:0] power_event;
        logic [1:0] mode_event;
        logic       combo_event;
        logic       selftest_event;
    } result_t;

endpackage

`default_nettype wire

[src/tkpc_cfg.sv]
// Configuration register file of the two-key press classifier.
// Depends on tkpc_pkg for register indexes, reset values and cfg_t.
`default_nettype none

module tkpc_cfg (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [tkpc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [tkpc_pkg::CFG_DATA_W-1:0]     cfg_data,
    output tkpc_pkg::cfg_t                           cfg
);

    tkpc_pkg::cfg_t cfg_reg;
    tkpc_pkg::cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            // unknown indexes fall through and leave the registers alone
            unique case (cfg_index)
                tkpc_pkg::REG_SHORT_MIN:       cfg_next.short_min = cfg_data;
                tkpc_pkg::REG_LONG_MARK:       cfg_next.long_mark = cfg_data;
                tkpc_pkg::REG_RELEASE_TICKS:
                    cfg_next.release_ticks = cfg_data[tkpc_pkg::QUIET_W-1:0];
                tkpc_pkg::REG_COMBO_MARK:      cfg_next.combo_mark = cfg_data;
                tkpc_pkg::REG_OTHER_KEY_LIMIT: cfg_next.other_key_limit = cfg_data;
                tkpc_pkg::REG_SELFTEST_LIMIT:  cfg_next.selftest_limit = cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.short_min       <= tkpc_pkg::RST_SHORT_MIN;
            cfg_reg.long_mark       <= tkpc_pkg::RST_LONG_MARK;
            cfg_reg.release_ticks   <= tkpc_pkg::RST_RELEASE_TICKS;
            cfg_reg.combo_mark      <= tkpc_pkg::RST_COMBO_MARK;
            cfg_reg.other_key_limit <= tkpc_pkg::RST_OTHER_KEY_LIMIT;
            cfg_reg.selftest_limit  <= tkpc_pkg::RST_SELFTEST_LIMIT;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

[src/tkpc_core.sv]
// Held-tick counters and event classification of the two-key press classifier.
// Updates its state once per accepted transaction; depends on tkpc_pkg.
`default_nettype none

module tkpc_core #(
    parameter int unsigned COUNTER_BITS = 16
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           in_fire,
    input  wire logic           tick,
    input  wire logic           key_power,
    input  wire logic           key_mode,
    input  wire tkpc_pkg::cfg_t cfg,
    output tkpc_pkg::result_t   result
);

    localparam int unsigned QW = tkpc_pkg::QUIET_W;

    logic [COUNTER_BITS-1:0] power_held_reg, power_held_next;
    logic [COUNTER_BITS-1:0] mode_held_reg,  mode_held_next;
    logic [COUNTER_BITS-1:0] both_held_reg,  both_held_next;
    logic [QW-1:0]           quiet_ticks_reg, quiet_ticks_next;
    logic [QW-1:0]           quiet_inc;

    // compare at 32 bits so counter and register widths never clip each other
    logic [31:0] pw, md, bt;
    logic [31:0] short_min_w, long_mark_w, combo_mark_w, other_lim_w, selftest_w;

    function automatic logic [1:0] classify(input logic [31:0] count,
                                            input logic [31:0] smin,
                                            input logic [31:0] lmark);
        logic [1:0] ev;
        if (count > smin && count < lmark) begin
            ev = tkpc_pkg::EV_SHORT;
        end else if (count > lmark) begin
            ev = tkpc_pkg::EV_LONG;
        end else begin
            ev = tkpc_pkg::EV_NONE;
        end
        return ev;
    endfunction

    assign short_min_w  = 32'(cfg.short_min);
    assign long_mark_w  = 32'(cfg.long_mark);
    assign combo_mark_w = 32'(cfg.combo_mark);
    assign other_lim_w  = 32'(cfg.other_key_limit);
    assign selftest_w   = 32'(cfg.selftest_limit);
    assign quiet_inc    = quiet_ticks_reg + QW'(1);

    always_comb begin
        power_held_next  = power_held_reg;
        mode_held_next   = mode_held_reg;
        both_held_next   = both_held_reg;
        quiet_ticks_next = quiet_ticks_reg;
        result           = '0;
        pw = '0;
        md = '0;
        bt = '0;
        if (tick) begin
            if (!key_power && !key_mode) begin
                if (quiet_inc < cfg.release_ticks) begin
                    quiet_ticks_next = quiet_inc;
                end else begin
                    quiet_ticks_next   = '0;
                    result.power_event = classify(32'(power_held_reg), short_min_w,
                                                  long_mark_w);
                    result.mode_event  = classify(32'(mode_held_reg), short_min_w,
                                                  long_mark_w);
                    power_held_next    = '0;
                    mode_held_next     = '0;
                end
            end else begin
                quiet_ticks_next = '0;
                if (key_power) begin
                    power_held_next = power_held_reg + COUNTER_BITS'(1);
                end
                if (key_mode) begin
                    mode_held_next = mode_held_reg + COUNTER_BITS'(1);
                end
                if (key_power && key_mode) begin
                    both_held_next = both_held_reg + COUNTER_BITS'(1);
                end
                pw = 32'(power_held_next);
                md = 32'(mode_held_next);
                bt = 32'(both_held_next);
                priority if (pw == long_mark_w && md < other_lim_w) begin
                    result.power_event = tkpc_pkg::EV_HOLD;
                end else if (md == long_mark_w && pw < other_lim_w) begin
                    result.mode_event = tkpc_pkg::EV_HOLD;
                end else if (pw == combo_mark_w && md > combo_mark_w) begin
                    result.combo_event = 1'b1;
                end else if (pw > combo_mark_w && md == combo_mark_w) begin
                    result.combo_event = 1'b1;
                end else if (bt > selftest_w) begin
                    result.selftest_event = 1'b1;
                end else begin
                    result = '0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            power_held_reg  <= '0;
            mode_held_reg   <= '0;
            both_held_reg   <= '0;
            quiet_ticks_reg <= '0;
        end else if (in_fire) begin
            power_held_reg  <= power_held_next;
            mode_held_reg   <= mode_held_next;
            both_held_reg   <= both_held_next;
            quiet_ticks_reg <= quiet_ticks_next;
        end
    end

endmodule

`default_nettype wire

[src/tkpc_skid.sv]
// Result register with a skid stage for the two-key press classifier.
// Holds up to two results so the input side keeps ready when the output
// first stalls; depends on tkpc_pkg for result_t.
`default_nettype none

module tkpc_skid (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              in_fire,
    output logic                   in_ready,
    input  wire tkpc_pkg::result_t in_data,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output tkpc_pkg::result_t      out_data
);

    logic              main_valid_reg, main_valid_next;
    logic              skid_valid_reg, skid_valid_next;
    tkpc_pkg::result_t main_data_reg,  main_data_next;
    tkpc_pkg::result_t skid_data_reg,  skid_data_next;

    assign in_ready  = !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_data_reg;

    always_comb begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_data_next  = main_data_reg;
        skid_data_next  = skid_data_reg;
        if (!main_valid_reg || out_ready) begin
            // output slot frees up: refill from skid first, then from input
            if (skid_valid_reg) begin
                main_valid_next = 1'b1;
                main_data_next  = skid_data_reg;
                skid_valid_next = 1'b0;
            end else begin
                main_valid_next = in_fire;
                main_data_next  = in_data;
            end
        end else if (in_fire) begin
            skid_valid_next = 1'b1;
            skid_data_next  = in_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        main_data_reg <= main_data_next;
        skid_data_reg <= skid_data_next;
    end

endmodule

`default_nettype wire

[src/two_key_press_classifier.sv]
// Top level of the two-key press classifier.
// Instantiates tkpc_cfg, tkpc_core and tkpc_skid; depends on tkpc_pkg.
//
//   channel  | direction | handshake            | payload
//   ---------+-----------+----------------------+-------------------------------------
//   s_       | in        | s_valid / s_ready    | s_tick, s_key_power, s_key_mode
//   m_       | out       | m_valid / m_ready    | m_power_event, m_mode_event,
//            |           |                      | m_combo_event, m_selftest_event
//   cfg_     | in        | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// One transaction per cycle while s_ready is high; each result is registered.
// The counter update and event compare sit between the input handshake and the
// result register, so each transaction sees the counters left by the one before.
// Synchronous active-low reset clears counters and both result slots, presets config.
// A two-entry result buffer keeps s_ready high as an m_ready stall begins;
// s_ready drops only while both slots are full. cfg_ready is always high.
`default_nettype none

module two_key_press_classifier #(
    parameter int unsigned COUNTER_BITS = 16
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic                                s_tick,
    input  wire logic                                s_key_power,
    input  wire logic                                s_key_mode,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic [1:0]                               m_power_event,
    output logic [1:0]                               m_mode_event,
    output logic                                     m_combo_event,
    output logic                                     m_selftest_event,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [tkpc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [tkpc_pkg::CFG_DATA_W-1:0]     cfg_data
);

    tkpc_pkg::cfg_t    cfg;
    tkpc_pkg::result_t core_result;
    tkpc_pkg::result_t out_result;
    logic              in_fire;

    assign in_fire = s_valid && s_ready;

    tkpc_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    tkpc_core #(
        .COUNTER_BITS (COUNTER_BITS)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_fire   (in_fire),
        .tick      (s_tick),
        .key_power (s_key_power),
        .key_mode  (s_key_mode),
        .cfg       (cfg),
        .result    (core_result)
    );

    tkpc_skid u_skid (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_fire   (in_fire),
        .in_ready  (s_ready),
        .in_data   (core_result),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (out_result)
    );

    assign m_power_event    = out_result.power_event;
    assign m_mode_event     = out_result.mode_event;
    assign m_combo_event    = out_result.combo_event;
    assign m_selftest_event = out_result.selftest_event;

endmodule

`default_nettype wire

[src/tkpc_checker.sv]
// Port-level checker for the two-key press classifier, bound to the top level.
// Depends on tkpc_pkg for the event codes.
`default_nettype none

module tkpc_checker (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       s_valid,
    input wire logic       s_ready,
    input wire logic       m_valid,
    input wire logic       m_ready,
    input wire logic [1:0] m_power_event,
    input wire logic [1:0] m_mode_event,
    input wire logic       m_combo_event,
    input wire logic       m_selftest_event
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_power_event)
            && $stable(m_mode_event) && $stable(m_combo_event)
            && $stable(m_selftest_event))
        else $error("stalled result changed or dropped");

    // no result without an accepted transaction in the cycle before
    a_no_invent: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(s_valid && s_ready))
        else $error("result appeared without an accepted input");

    // combination hold outranks self-test and excludes key events
    a_combo_alone: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_combo_event |-> m_power_event == tkpc_pkg::EV_NONE
            && m_mode_event == tkpc_pkg::EV_NONE && !m_selftest_event)
        else $error("combination event together with another event");

    // release classification never comes with hold-type events
    a_release_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_power_event == tkpc_pkg::EV_SHORT
            || m_power_event == tkpc_pkg::EV_LONG
            || m_mode_event == tkpc_pkg::EV_SHORT
            || m_mode_event == tkpc_pkg::EV_LONG)
        |-> !m_combo_event && !m_selftest_event
            && m_power_event != tkpc_pkg::EV_HOLD
            && m_mode_event != tkpc_pkg::EV_HOLD)
        else $error("release event mixed with hold event");

endmodule

bind two_key_press_classifier tkpc_checker u_tkpc_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .s_valid          (s_valid),
    .s_ready          (s_ready),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_power_event    (m_power_event),
    .m_mode_event     (m_mode_event),
    .m_combo_event    (m_combo_event),
    .m_selftest_event (m_selftest_event)
);

`default_nettype wire
